>>> design/assert_macros.svh
// Assertion macros shared by the execute unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset
`define VM_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// Check that the consequent holds in the cycle after the antecedent
`define VM_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> design/vmexe_pkg.sv
// Package: opcodes, status codes and queue entry type of the execute unit
`default_nettype none
package vmexe_pkg;
    localparam logic [4:0] OP_SYS  = 5'h00;
    localparam logic [4:0] OP_JMP  = 5'h01;
    localparam logic [4:0] OP_JZ   = 5'h02;
    localparam logic [4:0] OP_JP   = 5'h03;
    localparam logic [4:0] OP_JN   = 5'h04;
    localparam logic [4:0] OP_JNZ  = 5'h05;
    localparam logic [4:0] OP_JNP  = 5'h06;
    localparam logic [4:0] OP_JNN  = 5'h07;
    localparam logic [4:0] OP_NOT  = 5'h08;
    localparam logic [4:0] OP_STOP = 5'h0F;
    localparam logic [4:0] OP_MOV  = 5'h10;
    localparam logic [4:0] OP_ADD  = 5'h11;
    localparam logic [4:0] OP_SUB  = 5'h12;
    localparam logic [4:0] OP_MUL  = 5'h13;
    localparam logic [4:0] OP_DIV  = 5'h14;
    localparam logic [4:0] OP_CMP  = 5'h15;
    localparam logic [4:0] OP_SHL  = 5'h16;
    localparam logic [4:0] OP_SHR  = 5'h17;
    localparam logic [4:0] OP_SAR  = 5'h18;
    localparam logic [4:0] OP_AND  = 5'h19;
    localparam logic [4:0] OP_OR   = 5'h1A;
    localparam logic [4:0] OP_XOR  = 5'h1B;
    localparam logic [4:0] OP_SWAP = 5'h1C;
    localparam logic [4:0] OP_LDL  = 5'h1D;
    localparam logic [4:0] OP_LDH  = 5'h1E;
    localparam logic [4:0] OP_RND  = 5'h1F;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_PASS  = 2'd2;
    localparam logic [1:0] ST_UNDEF = 2'd3;

    // Instruction class decided by the front end
    localparam logic [2:0] CL_PASS  = 3'd0;
    localparam logic [2:0] CL_UNDEF = 3'd1;
    localparam logic [2:0] CL_JUMP  = 3'd2;
    localparam logic [2:0] CL_STOP  = 3'd3;
    localparam logic [2:0] CL_ALU   = 3'd4;
    localparam logic [2:0] CL_DIV   = 3'd5;

    // Classified instruction held in the queue
    typedef struct packed {
        logic [4:0]  op;
        logic [2:0]  cls;
        logic [31:0] a;
        logic [31:0] b;
    } vmexe_item_t;
endpackage
`default_nettype wire

>>> design/vmexe_front.sv
// Front end: accepts instructions, classifies them, two-entry queue
`default_nettype none
`include "assert_macros.svh"
module vmexe_front #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [4:0]           in_op,
    input  wire logic [31:0]          in_a,
    input  wire logic [31:0]          in_b,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output vmexe_pkg::vmexe_item_t    q_item
);
    vmexe_pkg::vmexe_item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push, pop;
    vmexe_pkg::vmexe_item_t item;

    // Sign extend operands from the word width
    function automatic logic [31:0] sx(input logic [31:0] v);
        logic [31:0] r;
        r = v;
        for (int i = WORD_BITS; i < 32; i++)
        begin
            r[i] = v[WORD_BITS-1];
        end
        return r;
    endfunction

    // Classify opcode
    always_comb
    begin
        item.op = in_op;
        item.a  = sx(in_a);
        item.b  = sx(in_b);
        case (in_op) inside
            vmexe_pkg::OP_SYS, vmexe_pkg::OP_RND:    item.cls = vmexe_pkg::CL_PASS;
            [vmexe_pkg::OP_JMP:vmexe_pkg::OP_JNN]:    item.cls = vmexe_pkg::CL_JUMP;
            vmexe_pkg::OP_STOP:                      item.cls = vmexe_pkg::CL_STOP;
            vmexe_pkg::OP_DIV:                       item.cls = vmexe_pkg::CL_DIV;
            vmexe_pkg::OP_NOT,
            [vmexe_pkg::OP_MOV:vmexe_pkg::OP_LDH]:    item.cls = vmexe_pkg::CL_ALU;
            default:                                 item.cls = vmexe_pkg::CL_UNDEF;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rp_reg];
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= item;
    end

    `VM_ASSERT_IMPL(a_no_overflow, clk, rst_n, cnt_reg == 2'd2, !push, "queue overflow")
    `VM_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3, "queue count range")
endmodule
`default_nettype wire

>>> design/vmexe_div.sv
// Iterative signed divider, one quotient bit per cycle
`default_nettype none
module vmexe_div #(
    parameter int WORD_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [31:0]      quotient,
    output logic [31:0]      remainder
);
    localparam int CW = $clog2(WORD_BITS + 1);
    logic [WORD_BITS-1:0] q_reg, r_reg, d_reg;
    logic [WORD_BITS:0]   trial;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg, done_reg, qneg_reg, rneg_reg;
    logic [WORD_BITS-1:0] ua, ub, qs, rs;
    logic [WORD_BITS-1:0] rsh;

    assign ua = dividend[WORD_BITS-1] ? -dividend[WORD_BITS-1:0] : dividend[WORD_BITS-1:0];
    assign ub = divisor[WORD_BITS-1]  ? -divisor[WORD_BITS-1:0]  : divisor[WORD_BITS-1:0];
    assign rsh   = {r_reg[WORD_BITS-2:0], q_reg[WORD_BITS-1]};
    assign trial = {r_reg[WORD_BITS-1], rsh} - {1'b0, d_reg};

    // Restoring step; done stays high until the next start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= CW'(WORD_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= ua;
            r_reg    <= '0;
            d_reg    <= ub;
            qneg_reg <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
            rneg_reg <= dividend[WORD_BITS-1];
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_BITS])
            begin
                r_reg <= trial[WORD_BITS-1:0];
                q_reg <= {q_reg[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                r_reg <= rsh;
                q_reg <= {q_reg[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign qs = qneg_reg ? -q_reg : q_reg;
    assign rs = rneg_reg ? -r_reg : r_reg;
    assign busy = busy_reg;
    assign done = done_reg;

    // Sign extend results to 32 bits
    always_comb
    begin
        quotient  = {{(32-WORD_BITS){qs[WORD_BITS-1]}}, qs};
        remainder = {{(32-WORD_BITS){rs[WORD_BITS-1]}}, rs};
    end
endmodule
`default_nettype wire

>>> design/vmexe_back.sv
// Back end: executes queued instructions, keeps condition flags, output register
`default_nettype none
`include "assert_macros.svh"
module vmexe_back #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [31:0]          code_segment,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  wire vmexe_pkg::vmexe_item_t q_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [143:0]              out_data
);
    localparam logic [31:0] WMASK = 32'hFFFFFFFF >> (32 - WORD_BITS);

    logic [1:0]   cf_reg, cf_next;
    logic         ov_reg;
    logic [143:0] od_reg;
    logic [143:0] res;
    logic         div_wait_reg;
    logic         can_load, fire, start_div;
    logic         div_busy, div_done;
    logic [31:0]  div_q, div_r;

    logic [31:0] a, b, r, dv, sv, rv, jt;
    logic        dw, sw, rw, jk, hl, setf, cond;
    logic [1:0]  st;
    logic [4:0]  n;
    logic [63:0] prod;

    function automatic logic [31:0] sx(input logic [31:0] v);
        logic [31:0] t;
        t = v;
        for (int i = WORD_BITS; i < 32; i++)
        begin
            t[i] = v[WORD_BITS-1];
        end
        return t;
    endfunction

    function automatic logic [1:0] flg(input logic [31:0] v);
        logic [31:0] w;
        w = v & WMASK;
        return {w[WORD_BITS-1], w == 32'd0};
    endfunction

    vmexe_div #(.WORD_BITS(WORD_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(start_div),
        .dividend(q_item.a), .divisor(q_item.b),
        .busy(div_busy), .done(div_done),
        .quotient(div_q), .remainder(div_r)
    );

    assign a = q_item.a;
    assign b = q_item.b;
    assign n = b[4:0];
    assign prod = a * b;
    assign can_load = !ov_reg || out_ready;

    // Execute one instruction
    always_comb
    begin
        r = '0; sv = '0; rv = '0; jt = '0; st = vmexe_pkg::ST_OK;
        dw = 1'b0; sw = 1'b0; rw = 1'b0; hl = 1'b0; setf = 1'b0; cond = 1'b0;
        case (q_item.op)
            vmexe_pkg::OP_SYS, vmexe_pkg::OP_RND: st = vmexe_pkg::ST_PASS;
            vmexe_pkg::OP_JMP: cond = 1'b1;
            vmexe_pkg::OP_JZ:  cond = (cf_reg == 2'd1);
            vmexe_pkg::OP_JP:  cond = (cf_reg == 2'd0);
            vmexe_pkg::OP_JN:  cond = (cf_reg == 2'd2);
            vmexe_pkg::OP_JNZ: cond = (cf_reg == 2'd0) || (cf_reg == 2'd2);
            vmexe_pkg::OP_JNP: cond = (cf_reg == 2'd1) || (cf_reg == 2'd2);
            vmexe_pkg::OP_JNN: cond = (cf_reg == 2'd0) || (cf_reg == 2'd1);
            vmexe_pkg::OP_NOT: begin r = ~a; dw = 1'b1; setf = 1'b1; end
            vmexe_pkg::OP_STOP: begin hl = 1'b1; jt = 32'hFFFFFFFF; end
            vmexe_pkg::OP_MOV: begin r = b; dw = 1'b1; end
            vmexe_pkg::OP_ADD: begin r = a + b; dw = 1'b1; setf = 1'b1; end
            vmexe_pkg::OP_SUB: begin r = a - b; dw = 1'b1; setf = 1'b1; end
            vmexe_pkg::OP_MUL: begin r = prod[31:0]; dw = 1'b1; setf = 1'b1; end
            vmexe_pkg::OP_DIV:
            begin
                if ((b & WMASK) == 32'd0)
                begin
                    st = vmexe_pkg::ST_DIV0;
                end
                else
                begin
                    r = div_q; rv = div_r; dw = 1'b1; rw = 1'b1; setf = 1'b1;
                end
            end
            vmexe_pkg::OP_CMP: begin r = a - b; setf = 1'b1; end
            vmexe_pkg::OP_SHL:
            begin
                r = (32'(n) >= WORD_BITS) ? 32'd0 : ((a & WMASK) << n);
                dw = 1'b1; setf = 1'b1;
            end
            vmexe_pkg::OP_SHR:
            begin
                r = (32'(n) >= WORD_BITS) ? 32'd0 : ((a & WMASK) >> n);
                dw = 1'b1; setf = 1'b1;
            end
            vmexe_pkg::OP_SAR:
            begin
                if (32'(n) >= WORD_BITS)
                begin
                    r = a[WORD_BITS-1] ? WMASK : 32'd0;
                end
                else
                begin
                    r = (a & WMASK) >> n;
                    if (a[WORD_BITS-1]) r = r | (WMASK & ~(WMASK >> n));
                end
                dw = 1'b1; setf = 1'b1;
            end
            vmexe_pkg::OP_AND: begin r = a & b; dw = 1'b1; setf = 1'b1; end
            vmexe_pkg::OP_OR:  begin r = a | b; dw = 1'b1; setf = 1'b1; end
            vmexe_pkg::OP_XOR: begin r = a ^ b; dw = 1'b1; setf = 1'b1; end
            vmexe_pkg::OP_SWAP: begin r = b; sv = sx(a); dw = 1'b1; sw = 1'b1; end
            vmexe_pkg::OP_LDL:
            begin
                r = (a & 32'hFFFF0000) | (b & 32'h0000FFFF); dw = 1'b1;
            end
            vmexe_pkg::OP_LDH:
            begin
                r = (a & 32'h0000FFFF) | ((b & 32'h0000FFFF) << 16); dw = 1'b1;
            end
            default: st = vmexe_pkg::ST_UNDEF;
        endcase
        jk = (q_item.cls == vmexe_pkg::CL_JUMP) && cond;
        if (jk) jt = code_segment | a;
        dv = dw ? sx(r) : 32'd0;
        cf_next = setf ? flg(r) : cf_reg;
        res = {7'b0, cf_next, st, hl, jt, jk, rw, rv, sw, sv, dw, dv};
    end

    // Divide by a nonzero divisor waits for the iterative unit; others finish at once
    assign start_div = q_valid && (q_item.cls == vmexe_pkg::CL_DIV) && !div_wait_reg
                       && ((b & WMASK) != 32'd0);
    assign fire = q_valid && can_load &&
                  ((q_item.cls != vmexe_pkg::CL_DIV) || ((b & WMASK) == 32'd0) ||
                   (div_wait_reg && div_done));
    assign q_ready = fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cf_reg       <= 2'd0;
            ov_reg       <= 1'b0;
            div_wait_reg <= 1'b0;
        end
        else
        begin
            if (start_div) div_wait_reg <= 1'b1;
            else if (fire) div_wait_reg <= 1'b0;
            if (fire)
            begin
                cf_reg <= cf_next;
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (fire) od_reg <= res;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    `VM_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
    `VM_ASSERT_IMPL(a_div_idle, clk, rst_n, start_div, !div_busy, "divider restarted")
endmodule
`default_nettype wire

>>> design/vm_alu_branch_execute_unit.sv
// Top level of the execute unit
//   channel   dir  signals                        contents
//   s_axis    in   s_axis_tvalid/tready/tdata     op, operand_a, operand_b
//   m_axis    out  m_axis_tvalid/tready/tdata     result fields
//   config    in   cfg_we/cfg_wdata               code_segment
// Non-divide: one per cycle through the queue unless the output stalls or a DIV waits.
// DIV with a nonzero divisor waits in the back end for the one-bit-per-cycle divider.
// Reset clears flags, code_segment and output valid, and empties the queue.
// A two-entry queue lets the front keep accepting while the back stalls, until full.
`default_nettype none
module vm_alu_branch_execute_unit #(
    parameter int WORD_BITS = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [71:0]  s_axis_tdata,   // op[4:0], operand_a[36:5], operand_b[68:37]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [143:0]      m_axis_tdata,   // dest_value, dest_write, source_value,
                                              // source_write, remainder_value,
                                              // remainder_write, jump_taken, jump_target,
                                              // halt, status, flags
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata
);
    logic [31:0] cs_reg;
    logic        q_valid, q_ready;
    vmexe_pkg::vmexe_item_t q_item;

    // Code segment register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cs_reg <= '0;
        else if (cfg_we) cs_reg <= cfg_wdata;
    end

    vmexe_front #(.WORD_BITS(WORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tdata[4:0]), .in_a(s_axis_tdata[36:5]), .in_b(s_axis_tdata[68:37]),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    vmexe_back #(.WORD_BITS(WORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .code_segment(cs_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
    );
endmodule
`default_nettype wire
